### rtl/core/chm_pkg.sv
// Shared constants and types for the chained hash map.
`default_nettype none

package chm_pkg;

  // Entry store size and derived widths
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Word field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int BKT_W    = 7;
  localparam int BCNT_W   = 8;
  localparam int ECNT_W   = 7;
  localparam int EXP_W    = 3;
  localparam int ENTRY_W  = KEY_W + VAL_W;

  // Bucket exponent ceiling: 128 buckets
  localparam logic [EXP_W-1:0] EXP_LIMIT = 3'd7;

  // Width of the load test products: count*5 against buckets*3
  localparam int LOAD_W = (CNT_W + 3 > BCNT_W + 2) ? CNT_W + 3 : BCNT_W + 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

### rtl/core/chm_ifs.sv
// Request and response channel interfaces of the chained hash map.
`default_nettype none

interface chm_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [chm_pkg::OP_W-1:0]      operation;
  logic signed [chm_pkg::KEY_W-1:0]     key;
  logic signed [chm_pkg::VAL_W-1:0]     value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface chm_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic        [chm_pkg::STAT_W-1:0]    status;
  logic signed [chm_pkg::VAL_W-1:0]     read_value;
  logic        [chm_pkg::BKT_W-1:0]     bucket;
  logic        [chm_pkg::BCNT_W-1:0]    bucket_count;
  logic        [chm_pkg::ECNT_W-1:0]    entry_count;

  modport source (output valid, output status, output read_value, output bucket,
                  output bucket_count, output entry_count, input ready);
  modport sink   (input valid, input status, input read_value, input bucket,
                  input bucket_count, input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/core/chm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module chm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/chained_hash_map.sv
// Top level of the chained hash map: request sequencer over the entry store.
//
// A request word on in_req carries an operation (insert or update, find,
// remove), a signed 32-bit key and a value. Each request gives exactly one
// response word on out_rsp: status, the value read on a find hit, the key's
// bucket, the bucket count and the entry count after the request.
// Keys and values live in one synchronous RAM; entry valid bits sit in flops.
// Every request sweeps all MAX_ENTRIES entries through the RAM read port,
// one per cycle, matching the key and locating the first free entry, then
// applies its update in the S_FINISH write-back.
// The request runs through S_SCAN and S_FINISH; the response word is
// registered and in_req.ready returns together with it, so a new request is
// only taken once the previous one has been written back.
// in_req.ready is high only between requests. The response register lets
// a new request be taken while the previous response waits; if the receiver
// still stalls when the next write-back is due, the write-back holds.
// Reset (synchronous, rst_n low) clears all valid bits, the entry count,
// sets one bucket and drops any pending response; no clearing pass needed.
`default_nettype none

module chained_hash_map (
  input  wire logic  clk,
  input  wire logic  rst_n,
  chm_req_if.sink    in_req,
  chm_rsp_if.source  out_rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                             state_r, state_nxt;

  // Latched request
  logic [chm_pkg::OP_W-1:0]           op_r, op_nxt;
  logic [chm_pkg::KEY_W-1:0]          key_r, key_nxt;
  logic [chm_pkg::VAL_W-1:0]          val_r, val_nxt;

  // Map state outside the RAM
  logic [chm_pkg::MAX_ENTRIES-1:0]    valid_r, valid_nxt;
  chm_pkg::cnt_t                      count_r, count_nxt;
  logic [chm_pkg::EXP_W-1:0]          exp_r, exp_nxt;

  // Sweep state
  chm_pkg::cnt_t                      scan_r, scan_nxt;
  logic                               cmp_vld_r, cmp_vld_nxt;
  chm_pkg::idx_t                      cmp_idx_r, cmp_idx_nxt;
  logic                               hit_r, hit_nxt;
  chm_pkg::idx_t                      hit_idx_r, hit_idx_nxt;
  logic [chm_pkg::VAL_W-1:0]          hit_val_r, hit_val_nxt;
  logic                               free_found_r, free_found_nxt;
  chm_pkg::idx_t                      free_idx_r, free_idx_nxt;

  // Response register
  logic                               out_valid_r, out_valid_nxt;
  logic [chm_pkg::STAT_W-1:0]         status_r, status_nxt;
  logic [chm_pkg::VAL_W-1:0]          rd_val_r, rd_val_nxt;
  logic [chm_pkg::BKT_W-1:0]          bucket_r, bucket_nxt;
  logic [chm_pkg::BCNT_W-1:0]         bcount_r, bcount_nxt;
  logic [chm_pkg::ECNT_W-1:0]         ecount_r, ecount_nxt;

  // RAM ports
  logic                               ram_we;
  chm_pkg::idx_t                      ram_waddr;
  logic [chm_pkg::ENTRY_W-1:0]        ram_wdata;
  chm_pkg::idx_t                      ram_raddr;
  logic [chm_pkg::ENTRY_W-1:0]        ram_rdata;

  // Load test and bucket helpers
  logic [chm_pkg::LOAD_W-1:0]         load_lhs;
  logic [chm_pkg::LOAD_W-1:0]         load_rhs;
  logic [chm_pkg::BCNT_W-1:0]         bcount_now;
  logic                               in_fire;
  logic                               out_free;

  chm_ram #(
    .WIDTH (chm_pkg::ENTRY_W),
    .DEPTH (chm_pkg::MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_fire   = in_req.valid && in_req.ready;
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign ram_raddr = scan_r[chm_pkg::IDX_W-1:0];

  assign load_lhs   = chm_pkg::LOAD_W'(count_r) * chm_pkg::LOAD_W'(5);
  assign load_rhs   = chm_pkg::LOAD_W'(bcount_now) * chm_pkg::LOAD_W'(3);
  assign bcount_now = chm_pkg::BCNT_W'(1) << exp_r;

  // Sequence one request: accept, sweep, write back
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    exp_nxt        = exp_r;
    scan_nxt       = scan_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_val_nxt    = hit_val_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    out_valid_nxt  = out_valid_r;
    status_nxt     = status_r;
    rd_val_nxt     = rd_val_r;
    bucket_nxt     = bucket_r;
    bcount_nxt     = bcount_r;
    ecount_nxt     = ecount_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_idx_r;
    ram_wdata      = {key_r, val_r};

    // Drop the response once taken
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_req.operation;
          key_nxt        = in_req.key;
          val_nxt        = in_req.value;
          scan_nxt       = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          // Grow the bucket count ahead of an insert when load >= 0.6 and below the exponent ceiling
          if (in_req.operation == chm_pkg::OP_INSERT && load_lhs >= load_rhs &&
              exp_r < chm_pkg::EXP_LIMIT) begin
            exp_nxt = exp_r + chm_pkg::EXP_W'(1);
          end
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read per cycle and track the first free entry
        if (scan_r < chm_pkg::CNT_W'(chm_pkg::MAX_ENTRIES)) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[chm_pkg::IDX_W-1:0];
          scan_nxt    = scan_r + chm_pkg::CNT_W'(1);
          if (!free_found_r && !valid_r[scan_r[chm_pkg::IDX_W-1:0]]) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = scan_r[chm_pkg::IDX_W-1:0];
          end
        end
        // Match the returned entry against the key
        if (cmp_vld_r) begin
          if (!hit_r && valid_r[cmp_idx_r] &&
              ram_rdata[chm_pkg::ENTRY_W-1:chm_pkg::VAL_W] == key_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            hit_val_nxt = ram_rdata[chm_pkg::VAL_W-1:0];
          end
          if (cmp_idx_r == chm_pkg::IDX_W'(chm_pkg::MAX_ENTRIES - 1)) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        // Hold the write-back until the response register frees up
        if (out_free) begin
          status_nxt = chm_pkg::ST_OK;
          rd_val_nxt = '0;
          unique case (op_r)
            chm_pkg::OP_INSERT: begin
              if (hit_r) begin
                ram_we    = 1'b1;
                ram_waddr = hit_idx_r;
              end else if (count_r >= chm_pkg::CNT_W'(chm_pkg::MAX_ENTRIES) ||
                           !free_found_r) begin
                status_nxt = chm_pkg::ST_FULL;
              end else begin
                ram_we                = 1'b1;
                ram_waddr             = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
                count_nxt             = count_r + chm_pkg::CNT_W'(1);
              end
            end
            chm_pkg::OP_FIND: begin
              if (hit_r) begin
                rd_val_nxt = hit_val_r;
              end else begin
                status_nxt = chm_pkg::ST_MISS;
              end
            end
            chm_pkg::OP_REMOVE: begin
              if (hit_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                if (count_r != '0) begin
                  count_nxt = count_r - chm_pkg::CNT_W'(1);
                end
              end else begin
                status_nxt = chm_pkg::ST_MISS;
              end
            end
            default: begin
              status_nxt = chm_pkg::ST_OK;
            end
          endcase
          bcount_nxt    = bcount_now;
          bucket_nxt    = key_r[chm_pkg::BKT_W-1:0] &
                          (chm_pkg::BKT_W'(7'h7F) >> (chm_pkg::EXP_LIMIT - exp_r));
          ecount_nxt    = chm_pkg::ECNT_W'(count_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      exp_r        <= '0;
      scan_r       <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      exp_r        <= exp_nxt;
      scan_r       <= scan_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    free_idx_r <= free_idx_nxt;
    status_r   <= status_nxt;
    rd_val_r   <= rd_val_nxt;
    bucket_r   <= bucket_nxt;
    bcount_r   <= bcount_nxt;
    ecount_r   <= ecount_nxt;
  end

  // Drive the channels
  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.read_value   = rd_val_r;
  assign out_rsp.bucket       = bucket_r;
  assign out_rsp.bucket_count = bcount_r;
  assign out_rsp.entry_count  = ecount_r;

endmodule

`default_nettype wire

### rtl/core/chm_checker.sv
// Port-level checks for the chained hash map, bound to the top level.
`default_nettype none

module chm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [chm_pkg::STAT_W-1:0]    status,
  input wire logic [chm_pkg::VAL_W-1:0]     read_value,
  input wire logic [chm_pkg::BKT_W-1:0]     bucket,
  input wire logic [chm_pkg::BCNT_W-1:0]    bucket_count,
  input wire logic [chm_pkg::ECNT_W-1:0]    entry_count
);

  // One request in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in flight");

  // A response never appears right after an accept
  a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("response rose one cycle after accept");

  // Bucket count is a power of two and the bucket lies below it
  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($onehot(bucket_count) && ({1'b0, bucket} < bucket_count)))
    else $error("bucket or bucket count out of range");

  // A stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) &&
      $stable(read_value) && $stable(bucket) && $stable(bucket_count) &&
      $stable(entry_count)))
    else $error("stalled response word changed");

endmodule

bind chained_hash_map chm_checker u_chm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .status       (out_rsp.status),
  .read_value   (out_rsp.read_value),
  .bucket       (out_rsp.bucket),
  .bucket_count (out_rsp.bucket_count),
  .entry_count  (out_rsp.entry_count)
);

`default_nettype wire

### bench/chained_hash_map_tb.sv
// Testbench for the chained hash map: random and directed requests checked against a shadow map.
`timescale 1ns / 1ps

module chained_hash_map_tb;

  localparam logic [chm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE  = 96;
  localparam int RAND_ITEMS = 1200;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 500;

  typedef struct {
    logic [chm_pkg::OP_W-1:0]  op;
    logic [chm_pkg::KEY_W-1:0] key;
    logic [chm_pkg::VAL_W-1:0] value;
  } map_req_t;

  typedef struct {
    logic [chm_pkg::STAT_W-1:0] status;
    logic [chm_pkg::VAL_W-1:0]  read_value;
    logic [chm_pkg::BKT_W-1:0]  bucket;
    logic [chm_pkg::BCNT_W-1:0] bucket_count;
    logic [chm_pkg::ECNT_W-1:0] entry_count;
  } map_rsp_t;

  logic clk;
  logic rst_n;

  chm_req_if req_ch ();
  chm_rsp_if rsp_ch ();

  chained_hash_map dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // Shadow copy of the map
  logic [chm_pkg::KEY_W-1:0] tbl_key  [chm_pkg::MAX_ENTRIES];
  logic [chm_pkg::VAL_W-1:0] tbl_val  [chm_pkg::MAX_ENTRIES];
  logic                      tbl_used [chm_pkg::MAX_ENTRIES];
  int                        tbl_count;
  int                        tbl_exp;

  map_req_t req_backlog[$];
  map_rsp_t due_replies[$];
  logic [chm_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

  int errors;
  int replies_seen;
  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_done;
  int stall_phase;

  // Clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Apply one request to the shadow map and return the reply it should give
  function automatic map_rsp_t apply_map_request(logic [chm_pkg::OP_W-1:0] op,
                                                 logic [chm_pkg::KEY_W-1:0] key,
                                                 logic [chm_pkg::VAL_W-1:0] value);
    map_rsp_t r;
    int hit;
    int slot;
    int nbuckets;
    logic [chm_pkg::BCNT_W-1:0] mask;
    r.status     = chm_pkg::ST_OK;
    r.read_value = '0;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < chm_pkg::MAX_ENTRIES; i++) begin
      if (tbl_used[i] && tbl_key[i] == key && hit < 0) hit = i;
      if (!tbl_used[i] && slot < 0) slot = i;
    end
    case (op)
      chm_pkg::OP_INSERT: begin
        // grow first, even when the insert only updates
        nbuckets = 1 << tbl_exp;
        if (tbl_count * 5 >= nbuckets * 3 && tbl_exp < int'(chm_pkg::EXP_LIMIT))
          tbl_exp++;
        if (hit >= 0) begin
          tbl_val[hit] = value;
        end else if (tbl_count >= chm_pkg::MAX_ENTRIES || slot < 0) begin
          r.status = chm_pkg::ST_FULL;
        end else begin
          tbl_key[slot]  = key;
          tbl_val[slot]  = value;
          tbl_used[slot] = 1'b1;
          tbl_count++;
        end
      end
      chm_pkg::OP_FIND: begin
        if (hit >= 0) r.read_value = tbl_val[hit];
        else r.status = chm_pkg::ST_MISS;
      end
      chm_pkg::OP_REMOVE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          if (tbl_count > 0) tbl_count--;
        end else begin
          r.status = chm_pkg::ST_MISS;
        end
      end
      default: ;
    endcase
    nbuckets       = 1 << tbl_exp;
    mask           = chm_pkg::BCNT_W'(nbuckets - 1);
    r.bucket       = key[chm_pkg::BKT_W-1:0] & mask[chm_pkg::BKT_W-1:0];
    r.bucket_count = chm_pkg::BCNT_W'(nbuckets);
    r.entry_count  = chm_pkg::ECNT_W'(tbl_count);
    return r;
  endfunction

  function automatic void push_req(logic [chm_pkg::OP_W-1:0] op,
                                   logic [chm_pkg::KEY_W-1:0] key,
                                   logic [chm_pkg::VAL_W-1:0] value);
    map_req_t m;
    m.op    = op;
    m.key   = key;
    m.value = value;
    req_backlog.insert(req_backlog.size(), m);
  endfunction

  // Mostly keys from the pool so that hits, updates and a full table happen
  function automatic logic [chm_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0h, got %0h", name, expected, actual);
      errors++;
    end
  endtask

  // Driver: offer words in bursts, hold a word until it is taken
  always @(posedge clk) begin : driver
    map_req_t item;
    logic nxt_valid;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        due_replies.insert(due_replies.size(),
                           apply_map_request(req_ch.operation, req_ch.key, req_ch.value));
      if (!(req_ch.valid && !req_ch.ready)) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_backlog.size() > 0) begin
          item             = req_backlog.pop_front();
          req_ch.operation <= item.op;
          req_ch.key       <= item.key;
          req_ch.value     <= item.value;
          nxt_valid        = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
            burst_left = $urandom_range(0, 12);
          end
        end
        req_ch.valid <= nxt_valid;
      end
    end
  end

  // Monitor: check each reply word, stall at random or on a pattern, one long hold-off
  always @(posedge clk) begin : monitor
    map_rsp_t due;
    logic rdy;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      replies_seen = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      stall_phase  = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_replies.size() == 0) begin
          $error("reply word with nothing outstanding");
          errors++;
        end else begin
          due = due_replies.pop_front();
          check_field("status", 32'(due.status), 32'(rsp_ch.status));
          check_field("read_value", due.read_value, rsp_ch.read_value);
          check_field("bucket", 32'(due.bucket), 32'(rsp_ch.bucket));
          check_field("bucket_count", 32'(due.bucket_count), 32'(rsp_ch.bucket_count));
          check_field("entry_count", 32'(due.entry_count), 32'(rsp_ch.entry_count));
        end
        replies_seen++;
        if (replies_seen == HOLD_AT && !hold_done) begin
          hold_left = HOLD_LEN;
          hold_done = 1'b1;
        end
      end
      stall_phase = (stall_phase + 1) % 11;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case ((replies_seen / 100) % 3)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(1) == 1);
          default: rdy = (stall_phase > 3);
        endcase
      end
      rsp_ch.ready <= rdy;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int phase;
    int r;
    int total;
    logic [chm_pkg::OP_W-1:0] op;
    errors           = 0;
    req_ch.valid     = 1'b0;
    req_ch.operation = chm_pkg::OP_INSERT;
    req_ch.key       = '0;
    req_ch.value     = '0;
    rsp_ch.ready     = 1'b0;
    tbl_count        = 0;
    tbl_exp          = 0;
    for (int i = 0; i < chm_pkg::MAX_ENTRIES; i++) tbl_used[i] = 1'b0;
    rst_n = 1'b0;

    // Pool: extremes, small keys, keys sharing low bits, random keys
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    for (int i = 4; i < 24; i++) key_pool[i] = chm_pkg::KEY_W'(i);
    for (int i = 24; i < 48; i++) key_pool[i] = (($urandom & 32'h01FF_FFFF) << 7) | 32'd5;
    for (int i = 48; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Directed: misses on empty map, extremes, growth, an update, unused op
    push_req(chm_pkg::OP_FIND,    32'h0000_0000, 32'h0);
    push_req(chm_pkg::OP_REMOVE,  32'h0000_0005, 32'h0);
    push_req(chm_pkg::OP_INSERT,  32'h0000_0000, 32'h1234_5678);
    push_req(chm_pkg::OP_INSERT,  32'h7FFF_FFFF, 32'h8000_0000);
    push_req(chm_pkg::OP_INSERT,  32'h8000_0000, 32'h7FFF_FFFF);
    push_req(chm_pkg::OP_INSERT,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(chm_pkg::OP_FIND,    32'h7FFF_FFFF, 32'h0);
    push_req(chm_pkg::OP_FIND,    32'h8000_0000, 32'hFFFF_FFFF);
    push_req(chm_pkg::OP_FIND,    32'hFFFF_FFFF, 32'h0);
    push_req(chm_pkg::OP_INSERT,  32'h0000_0000, 32'hDEAD_BEEF);
    push_req(chm_pkg::OP_FIND,    32'h0000_0000, 32'h0);
    push_req(OP_UNUSED,           32'h55AA_55AA, 32'hFFFF_FFFF);
    push_req(OP_UNUSED,           32'hAA55_AA55, 32'h0000_0000);
    push_req(chm_pkg::OP_REMOVE,  32'h7FFF_FFFF, 32'h0);
    push_req(chm_pkg::OP_FIND,    32'h7FFF_FFFF, 32'h0);
    push_req(chm_pkg::OP_REMOVE,  32'h7FFF_FFFF, 32'h0);
    push_req(chm_pkg::OP_INSERT,  32'h7FFF_FFFF, 32'h0000_0000);
    push_req(chm_pkg::OP_FIND,    32'h0000_007B, 32'h0);
    push_req(chm_pkg::OP_INSERT,  32'hFFFF_FF80, 32'h0000_0001);
    push_req(chm_pkg::OP_FIND,    32'hFFFF_FF80, 32'h0);

    // Random: phases of filling, mixing, draining and lookups
    for (int n = 0; n < RAND_ITEMS; n++) begin
      phase = (n / 150) % 4;
      r     = $urandom_range(99);
      if (r < 3) op = OP_UNUSED;
      else begin
        case (phase)
          0: op = (r < 80) ? chm_pkg::OP_INSERT :
                  (r < 90) ? chm_pkg::OP_FIND : chm_pkg::OP_REMOVE;
          1: op = (r < 40) ? chm_pkg::OP_INSERT :
                  (r < 70) ? chm_pkg::OP_FIND : chm_pkg::OP_REMOVE;
          2: op = (r < 20) ? chm_pkg::OP_INSERT :
                  (r < 40) ? chm_pkg::OP_FIND : chm_pkg::OP_REMOVE;
          default: op = (r < 30) ? chm_pkg::OP_INSERT :
                        (r < 80) ? chm_pkg::OP_FIND : chm_pkg::OP_REMOVE;
        endcase
      end
      push_req(op, pick_key(), $urandom);
    end
    total = req_backlog.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: wait for every reply word, then let the block settle
    while (replies_seen < total)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (due_replies.size() != 0) begin
      $error("replies still outstanding at end of run");
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
